>>> rtl/core/pfac_pkg.sv
// types and constants shared by the pet flap access controller
`default_nettype none
package pfac_pkg;

  typedef enum logic [2:0] {
    FLAP_NORMAL = 3'd0,
    FLAP_VET    = 3'd1,
    FLAP_CLOSED = 3'd2,
    FLAP_NIGHT  = 3'd3,
    FLAP_LEARN  = 3'd4,
    FLAP_CLEAR  = 3'd5,
    FLAP_OPEN   = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    BEEP_NONE        = 3'd0,
    BEEP_SHORT       = 3'd1,
    BEEP_LONG        = 3'd2,
    BEEP_PLAIN       = 3'd3,
    BEEP_SERIES      = 3'd4,
    BEEP_SERIES_LONG = 3'd5
  } beep_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_GREEN = 2'd1,
    EV_RED   = 2'd2,
    EV_BOTH  = 2'd3
  } press_ev_t;

  // menu entries
  localparam logic [2:0] MENU_EXIT      = 3'd1;
  localparam logic [2:0] MENU_OPEN      = 3'd2;
  localparam logic [2:0] MENU_SILENT    = 3'd3;
  localparam logic [2:0] MENU_THRESHOLD = 3'd4;
  localparam logic [2:0] MENU_LOCK_TIME = 3'd5;
  localparam logic [2:0] MENU_SIX       = 3'd6;
  localparam logic [2:0] MENU_TIMER     = 3'd7;
  localparam logic [2:0] MENU_FIRST     = 3'd1;
  localparam logic [2:0] MENU_LAST      = 3'd7;

  // configuration register indexes
  localparam logic [2:0] REG_LOCK_RETURN = 3'd0;
  localparam logic [2:0] REG_NIGHT_GAP   = 3'd1;
  localparam logic [2:0] REG_SHORT_PRESS = 3'd2;
  localparam logic [2:0] REG_VET_PRESS   = 3'd3;
  localparam logic [2:0] REG_LEARN_PRESS = 3'd4;
  localparam logic [2:0] REG_LONG_HOLD   = 3'd5;

  localparam logic [14:0] LOCK_RETURN_RESET = 15'd4000;
  localparam logic [14:0] LOCK_RETURN_MIN   = 15'd1000;
  localparam logic [14:0] LOCK_RETURN_MAX   = 15'd25000;
  localparam logic [5:0]  NIGHT_GAP_RESET   = 6'd5;
  localparam logic [15:0] SHORT_PRESS_RESET = 16'd2000;
  localparam logic [15:0] VET_PRESS_RESET   = 16'd5000;
  localparam logic [15:0] LEARN_PRESS_RESET = 16'd10000;
  localparam logic [15:0] LONG_HOLD_RESET   = 16'd30000;
  localparam int          THRESHOLD_RESET   = 512;
  localparam logic [2:0]  SERIES_FIVE       = 3'd5;

  typedef struct packed {
    mode_t mode;
    logic  out_l;
    logic  in_l;
  } latch_t;

endpackage
`default_nettype wire

>>> rtl/core/pet_flap_access_controller_top.sv
// pet flap access controller: button classing, flap modes, latches and indicators
//
//  channel | signals                              | accepted when
//  --------+--------------------------------------+----------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser    | s_tvalid && s_tready
//  result  | m_tvalid m_tready m_tdata            | m_tvalid && m_tready
//  config  | cfg_valid cfg_ready cfg_index cfg_data | cfg_valid && cfg_ready
//
// one tick per cycle: each transaction is worked out by the next-state logic in the
// cycle it is accepted and its result appears in the output register in the next cycle.
// s_tready stays high while the output register is empty or being drained, so a
// stalled result holds only the input side; cfg_ready is always high.
// rst is synchronous and clears all control state to its reset values.
`default_nettype none
module pet_flap_access_controller_top
  import pfac_pkg::*;
#(
  parameter int LIGHT_BITS = 10,
  parameter int BLINK_BIT  = 9,
  parameter int TIMER_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // green_down[0] red_down[1] light_level[11:2] tag_match[12] zero[15:13]
  input  wire logic [15:0] s_tdata,
  // light_valid[0]
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // mode_now[2:0] out_lock[3] in_lock[4] green_ind[5] red_led[6] beep_kind[9:7]
  // beep_count[12:10] learn_pulse[13] clear_pulse[14] menu_active[15]
  // menu_item[18:16] admitted[19] zero[23:20]
  output logic [23:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int LW = (LIGHT_BITS > 10) ? LIGHT_BITS : 10;
  localparam logic [LW-1:0] LIGHT_MASK = LW'((64'd1 << LIGHT_BITS) - 64'd1);
  localparam int TW = BLINK_BIT + 1;

  // configuration
  logic [14:0] lock_return_ms;
  logic [5:0]  night_gap;
  logic [15:0] short_press_ms, vet_press_ms, learn_press_ms, long_hold_ms;

  // state
  mode_t                 flap_mode;
  logic                  out_locked, in_locked;
  logic                  green_was_down, red_was_down, both_seen;
  logic [TIMER_BITS-1:0] press_time;
  logic                  menu_open, silent_on, keys_locked;
  logic [2:0]            menu_entry;
  logic [LW-1:0]         light_now, light_threshold;
  logic [14:0]           unlock_left;
  logic [TW-1:0]         tick_count;

  mode_t                 flap_mode_next;
  logic                  out_locked_next, in_locked_next;
  logic                  both_seen_next;
  logic [TIMER_BITS-1:0] press_time_next;
  logic                  menu_open_next, silent_on_next, keys_locked_next;
  logic [2:0]            menu_entry_next;
  logic [LW-1:0]         light_now_next, light_threshold_next;
  logic [14:0]           unlock_left_next;
  logic [TW-1:0]         tick_count_next;
  logic [23:0]           result_next;

  logic in_accept;
  assign in_accept = s_tvalid && s_tready;
  assign s_tready  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  function automatic latch_t set_mode(input mode_t m);
    latch_t r;
    r.mode = m;
    case (m)
      FLAP_VET, FLAP_CLOSED: begin
        r.out_l = 1'b1;
        r.in_l  = 1'b1;
      end
      FLAP_OPEN: begin
        r.out_l = 1'b0;
        r.in_l  = 1'b0;
      end
      FLAP_NORMAL, FLAP_NIGHT, FLAP_LEARN, FLAP_CLEAR: begin
        r.out_l = 1'b0;
        r.in_l  = 1'b1;
      end
      default: begin
        r.mode  = FLAP_NORMAL;
        r.out_l = 1'b0;
        r.in_l  = 1'b1;
      end
    endcase
    return r;
  endfunction

  logic                  g, r, blink, may_open, green_ind, red_led;
  logic                  learn_p, clear_p, admitted;
  beep_t                 beep_kind;
  logic [2:0]            beep_count;
  press_ev_t             ev;
  logic [TIMER_BITS-1:0] t;
  logic [14:0]           dur;
  latch_t                lt;
  logic [LW:0]           light_plus_gap;

  always_comb begin
    g = s_tdata[0];
    r = s_tdata[1];
    green_ind = 1'b0;
    red_led   = 1'b0;
    may_open  = 1'b0;
    learn_p   = 1'b0;
    clear_p   = 1'b0;
    admitted  = 1'b0;
    beep_kind = BEEP_NONE;
    beep_count = 3'd0;
    ev = EV_NONE;
    lt = '0;

    flap_mode_next       = flap_mode;
    out_locked_next      = out_locked;
    in_locked_next       = in_locked;
    both_seen_next       = both_seen;
    menu_open_next       = menu_open;
    menu_entry_next      = menu_entry;
    silent_on_next       = silent_on;
    keys_locked_next     = keys_locked;
    light_threshold_next = light_threshold;
    unlock_left_next     = unlock_left;

    light_now_next = s_tuser[0] ? (LW'(s_tdata[11:2]) & LIGHT_MASK) : light_now;
    tick_count_next = tick_count + TW'(1);
    blink = tick_count_next[BLINK_BIT];

    if (unlock_left_next != 15'd0) begin
      unlock_left_next = unlock_left_next - 15'd1;
      if (unlock_left_next == 15'd0) in_locked_next = 1'b1;
    end

    light_plus_gap = {1'b0, light_now_next} + (LW + 1)'(night_gap);

    case (flap_mode)
      FLAP_NORMAL: may_open = 1'b1;
      FLAP_VET: begin
        green_ind = blink;
        may_open  = 1'b1;
      end
      FLAP_CLOSED: begin
        green_ind = blink;
        red_led   = blink;
      end
      FLAP_LEARN: begin
        learn_p = 1'b1;
        lt = set_mode(FLAP_NORMAL);
        flap_mode_next = lt.mode; out_locked_next = lt.out_l; in_locked_next = lt.in_l;
        unlock_left_next = 15'd0;
      end
      FLAP_CLEAR: begin
        clear_p = 1'b1;
        lt = set_mode(FLAP_NORMAL);
        flap_mode_next = lt.mode; out_locked_next = lt.out_l; in_locked_next = lt.in_l;
        unlock_left_next = 15'd0;
      end
      FLAP_OPEN: red_led = blink;
      FLAP_NIGHT: begin
        if ((light_now_next > light_threshold) && !out_locked_next) begin
          out_locked_next = 1'b1; in_locked_next = 1'b1; unlock_left_next = 15'd0;
        end else if ((light_plus_gap < {1'b0, light_threshold}) && out_locked_next) begin
          out_locked_next = 1'b0; in_locked_next = 1'b1; unlock_left_next = 15'd0;
        end
        green_ind = out_locked_next;
        red_led   = 1'b1;
        may_open  = 1'b1;
      end
      default: begin
        lt = set_mode(FLAP_NORMAL);
        flap_mode_next = lt.mode; out_locked_next = lt.out_l; in_locked_next = lt.in_l;
        unlock_left_next = 15'd0;
      end
    endcase

    // tag admission, clamped open time
    if (lock_return_ms < LOCK_RETURN_MIN)      dur = LOCK_RETURN_MIN;
    else if (lock_return_ms > LOCK_RETURN_MAX) dur = LOCK_RETURN_MAX;
    else                                       dur = lock_return_ms;
    if (may_open && s_tdata[12] && (unlock_left_next == 15'd0)) begin
      unlock_left_next = dur;
      in_locked_next   = 1'b0;
      admitted         = 1'b1;
      if (!silent_on) beep_kind = BEEP_PLAIN;
    end

    // press timer saturates
    t = (press_time != '1) ? press_time + TIMER_BITS'(1) : press_time;
    press_time_next = t;
    if (g && !green_was_down) begin
      press_time_next = '0; both_seen_next = 1'b0;
    end else if (!g && green_was_down) begin
      ev = both_seen ? EV_BOTH : EV_GREEN;
    end else if (g && green_was_down) begin
      if (r) both_seen_next = 1'b1;
    end else if (r && !red_was_down) begin
      press_time_next = '0; both_seen_next = 1'b0;
    end else if (!r && red_was_down) begin
      ev = EV_RED;
    end

    if (ev == EV_GREEN && !keys_locked) begin
      if (t > TIMER_BITS'(long_hold_ms)) begin
        beep_kind = BEEP_SERIES_LONG; beep_count = SERIES_FIVE;
        lt = set_mode(FLAP_NORMAL);
        flap_mode_next = lt.mode; out_locked_next = lt.out_l; in_locked_next = lt.in_l;
        unlock_left_next = 15'd0;
        green_ind = 1'b0; red_led = 1'b0;
      end else if (menu_open) begin
        menu_entry_next = (menu_entry <= MENU_FIRST) ? MENU_LAST : menu_entry - 3'd1;
        beep_kind = BEEP_SERIES; beep_count = menu_entry_next;
      end else if (t > TIMER_BITS'(learn_press_ms)) begin
        lt = set_mode(FLAP_LEARN);
        flap_mode_next = lt.mode; out_locked_next = lt.out_l; in_locked_next = lt.in_l;
        unlock_left_next = 15'd0;
      end
    end else if (ev == EV_RED) begin
      if (t > TIMER_BITS'(long_hold_ms)) begin
        keys_locked_next = !keys_locked;
        beep_kind = BEEP_SERIES; beep_count = SERIES_FIVE;
      end else if (keys_locked) begin
        beep_kind = beep_kind;
      end else if (menu_open) begin
        menu_entry_next = (menu_entry >= MENU_LAST) ? MENU_FIRST : menu_entry + 3'd1;
        beep_kind = BEEP_SERIES; beep_count = menu_entry_next;
      end else if (t > TIMER_BITS'(vet_press_ms)) begin
        lt = set_mode((flap_mode_next == FLAP_VET) ? FLAP_NORMAL : FLAP_VET);
        flap_mode_next = lt.mode; out_locked_next = lt.out_l; in_locked_next = lt.in_l;
        unlock_left_next = 15'd0;
        beep_kind = BEEP_SHORT; beep_count = 3'd0;
      end else if (t < TIMER_BITS'(short_press_ms)) begin
        lt = set_mode((flap_mode_next == FLAP_NIGHT) ? FLAP_NORMAL : FLAP_NIGHT);
        flap_mode_next = lt.mode; out_locked_next = lt.out_l; in_locked_next = lt.in_l;
        unlock_left_next = 15'd0;
        beep_kind = BEEP_SHORT; beep_count = 3'd0;
      end
    end else if (ev == EV_BOTH && !(keys_locked && (t < TIMER_BITS'(long_hold_ms)))) begin
      if (t > TIMER_BITS'(long_hold_ms)) begin
        lt = set_mode(FLAP_CLEAR);
        flap_mode_next = lt.mode; out_locked_next = lt.out_l; in_locked_next = lt.in_l;
        unlock_left_next = 15'd0;
      end else if (menu_open) begin
        menu_open_next = 1'b0;
        case (menu_entry)
          MENU_EXIT: begin
            beep_kind = BEEP_SHORT; beep_count = 3'd0;
          end
          MENU_OPEN: begin
            lt = set_mode(FLAP_OPEN);
            flap_mode_next = lt.mode; out_locked_next = lt.out_l; in_locked_next = lt.in_l;
            unlock_left_next = 15'd0;
            beep_kind = BEEP_SHORT; beep_count = 3'd0;
          end
          MENU_SILENT: begin
            silent_on_next = !silent_on;
            beep_kind = BEEP_SHORT; beep_count = 3'd0;
          end
          MENU_THRESHOLD: begin
            light_threshold_next = light_now_next;
            beep_kind = BEEP_SHORT; beep_count = 3'd0;
          end
          MENU_SIX, MENU_TIMER: begin
            beep_kind = BEEP_SHORT; beep_count = 3'd0;
          end
          // lock time entry closes silently
          MENU_LOCK_TIME: beep_kind = beep_kind;
          default: beep_kind = beep_kind;
        endcase
      end else if (t > TIMER_BITS'(short_press_ms)) begin
        menu_open_next = 1'b1; menu_entry_next = MENU_FIRST;
        beep_kind = BEEP_LONG; beep_count = 3'd0;
      end
    end

    if (menu_open_next) green_ind = 1'b1;

    result_next = {4'd0, admitted, menu_entry_next, menu_open_next, clear_p, learn_p,
                   beep_count, beep_kind, red_led, green_ind, in_locked_next,
                   out_locked_next, flap_mode_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_return_ms <= LOCK_RETURN_RESET;
      night_gap      <= NIGHT_GAP_RESET;
      short_press_ms <= SHORT_PRESS_RESET;
      vet_press_ms   <= VET_PRESS_RESET;
      learn_press_ms <= LEARN_PRESS_RESET;
      long_hold_ms   <= LONG_HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOCK_RETURN: lock_return_ms <= cfg_data[14:0];
        REG_NIGHT_GAP:   night_gap      <= cfg_data[5:0];
        REG_SHORT_PRESS: short_press_ms <= cfg_data;
        REG_VET_PRESS:   vet_press_ms   <= cfg_data;
        REG_LEARN_PRESS: learn_press_ms <= cfg_data;
        REG_LONG_HOLD:   long_hold_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flap_mode       <= FLAP_NORMAL;
      out_locked      <= 1'b0;
      in_locked       <= 1'b1;
      green_was_down  <= 1'b0;
      red_was_down    <= 1'b0;
      press_time      <= '0;
      both_seen       <= 1'b0;
      menu_open       <= 1'b0;
      menu_entry      <= MENU_FIRST;
      silent_on       <= 1'b0;
      keys_locked     <= 1'b0;
      light_now       <= '0;
      light_threshold <= LW'(THRESHOLD_RESET);
      unlock_left     <= 15'd0;
      tick_count      <= '0;
    end else if (in_accept) begin
      flap_mode       <= flap_mode_next;
      out_locked      <= out_locked_next;
      in_locked       <= in_locked_next;
      green_was_down  <= g;
      red_was_down    <= r;
      press_time      <= press_time_next;
      both_seen       <= both_seen_next;
      menu_open       <= menu_open_next;
      menu_entry      <= menu_entry_next;
      silent_on       <= silent_on_next;
      keys_locked     <= keys_locked_next;
      light_now       <= light_now_next;
      light_threshold <= light_threshold_next;
      unlock_left     <= unlock_left_next;
      tick_count      <= tick_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) m_tdata <= result_next;
  end

endmodule
`default_nettype wire

>>> test/pet_flap_access_controller_top_test.sv
// testbench for the pet flap access controller: tick stream in, predicted outcome checked out
module pet_flap_access_controller_top_test;
  import pfac_pkg::*;

  typedef struct {
    mode_t     mode;
    bit        out_lock;
    bit        in_lock;
    bit        green_ind;
    bit        red_led;
    beep_t     beep;
    bit [2:0]  beep_count;
    bit        learn_pulse;
    bit        clear_pulse;
    bit        menu_active;
    bit [2:0]  menu_item;
    bit        admitted;
  } flap_outcome_t;

  class flap_checker;
    bit [14:0] lock_return;
    bit [5:0]  night_gap;
    bit [15:0] short_ms, vet_ms, learn_ms, long_ms;
    mode_t     flap_mode;
    bit        out_locked, in_locked, green_was, red_was, both_seen;
    bit        menu_open, silent_on, keys_locked;
    bit [2:0]  menu_entry;
    bit [15:0] press_time;
    bit [9:0]  light_now, light_thr, tick_count;
    bit [14:0] unlock_left;
    flap_outcome_t expected_outcomes[$];
    int        failures;

    function new();
      lock_return = LOCK_RETURN_RESET;
      night_gap   = NIGHT_GAP_RESET;
      short_ms    = SHORT_PRESS_RESET;
      vet_ms      = VET_PRESS_RESET;
      learn_ms    = LEARN_PRESS_RESET;
      long_ms     = LONG_HOLD_RESET;
      flap_mode   = FLAP_NORMAL;
      out_locked  = 1'b0;
      in_locked   = 1'b1;
      green_was   = 1'b0;
      red_was     = 1'b0;
      both_seen   = 1'b0;
      menu_open   = 1'b0;
      silent_on   = 1'b0;
      keys_locked = 1'b0;
      menu_entry  = MENU_FIRST;
      press_time  = '0;
      light_now   = '0;
      light_thr   = 10'(THRESHOLD_RESET);
      tick_count  = '0;
      unlock_left = '0;
      failures    = 0;
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] value);
      case (idx)
        REG_LOCK_RETURN: lock_return = value[14:0];
        REG_NIGHT_GAP:   night_gap = value[5:0];
        REG_SHORT_PRESS: short_ms = value;
        REG_VET_PRESS:   vet_ms = value;
        REG_LEARN_PRESS: learn_ms = value;
        REG_LONG_HOLD:   long_ms = value;
        default: ;
      endcase
    endfunction

    function void set_mode(mode_t m);
      out_locked  = (m == FLAP_VET || m == FLAP_CLOSED);
      in_locked   = (m != FLAP_OPEN);
      unlock_left = '0;
      flap_mode   = m;
    endfunction

    function void note_tick(logic [15:0] data, logic light_valid);
      bit g, r, tag, blink, may_open;
      bit [15:0] t;
      bit [14:0] hold;
      press_ev_t ev;
      flap_outcome_t o;
      g   = data[0];
      r   = data[1];
      tag = data[12];
      o.green_ind   = 1'b0;
      o.red_led     = 1'b0;
      o.learn_pulse = 1'b0;
      o.clear_pulse = 1'b0;
      o.admitted    = 1'b0;
      o.beep        = BEEP_NONE;
      o.beep_count  = '0;
      may_open      = 1'b0;

      if (light_valid) light_now = data[11:2];
      tick_count++;
      blink = tick_count[9];
      if (unlock_left != 0) begin
        unlock_left--;
        if (unlock_left == 0) in_locked = 1'b1;
      end

      case (flap_mode)
        FLAP_NORMAL: may_open = 1'b1;
        FLAP_VET: begin
          o.green_ind = blink;
          may_open = 1'b1;
        end
        FLAP_CLOSED: begin
          o.green_ind = blink;
          o.red_led = blink;
        end
        FLAP_LEARN: begin
          o.learn_pulse = 1'b1;
          set_mode(FLAP_NORMAL);
        end
        FLAP_CLEAR: begin
          o.clear_pulse = 1'b1;
          set_mode(FLAP_NORMAL);
        end
        FLAP_OPEN: o.red_led = blink;
        FLAP_NIGHT: begin
          // hysteresis: lock above the threshold, release only a gap below it
          if (light_now > light_thr && !out_locked) begin
            out_locked = 1'b1;
            in_locked = 1'b1;
            unlock_left = '0;
          end else if (int'(light_now) + int'(night_gap) < int'(light_thr) && out_locked) begin
            out_locked = 1'b0;
            in_locked = 1'b1;
            unlock_left = '0;
          end
          o.green_ind = out_locked;
          o.red_led = 1'b1;
          may_open = 1'b1;
        end
        default: set_mode(FLAP_NORMAL);
      endcase

      if (may_open && tag && unlock_left == 0) begin
        hold = lock_return;
        if (hold < LOCK_RETURN_MIN) hold = LOCK_RETURN_MIN;
        if (hold > LOCK_RETURN_MAX) hold = LOCK_RETURN_MAX;
        unlock_left = hold;
        in_locked = 1'b0;
        o.admitted = 1'b1;
        if (!silent_on) o.beep = BEEP_PLAIN;
      end

      if (press_time != '1) press_time++;
      t  = press_time;
      ev = EV_NONE;
      if (g && !green_was) begin
        press_time = '0;
        both_seen = 1'b0;
      end else if (!g && green_was) begin
        ev = both_seen ? EV_BOTH : EV_GREEN;
      end else if (g && green_was) begin
        if (r) both_seen = 1'b1;
      end else if (r && !red_was) begin
        press_time = '0;
        both_seen = 1'b0;
      end else if (!r && red_was) begin
        ev = EV_RED;
      end
      green_was = g;
      red_was   = r;

      case (ev)
        EV_GREEN: if (!keys_locked) begin
          if (t > long_ms) begin
            o.beep = BEEP_SERIES_LONG;
            o.beep_count = SERIES_FIVE;
            set_mode(FLAP_NORMAL);
            o.green_ind = 1'b0;
            o.red_led = 1'b0;
          end else if (menu_open) begin
            menu_entry = (menu_entry <= MENU_FIRST) ? MENU_LAST : menu_entry - 3'd1;
            o.beep = BEEP_SERIES;
            o.beep_count = menu_entry;
          end else if (t > learn_ms) begin
            set_mode(FLAP_LEARN);
          end
        end
        EV_RED: begin
          if (t > long_ms) begin
            keys_locked = !keys_locked;
            o.beep = BEEP_SERIES;
            o.beep_count = SERIES_FIVE;
          end else if (!keys_locked) begin
            if (menu_open) begin
              menu_entry = (menu_entry >= MENU_LAST) ? MENU_FIRST : menu_entry + 3'd1;
              o.beep = BEEP_SERIES;
              o.beep_count = menu_entry;
            end else if (t > vet_ms) begin
              set_mode(flap_mode == FLAP_VET ? FLAP_NORMAL : FLAP_VET);
              o.beep = BEEP_SHORT;
            end else if (t < short_ms) begin
              set_mode(flap_mode == FLAP_NIGHT ? FLAP_NORMAL : FLAP_NIGHT);
              o.beep = BEEP_SHORT;
            end
          end
        end
        EV_BOTH: if (!(keys_locked && t < long_ms)) begin
          if (t > long_ms) begin
            set_mode(FLAP_CLEAR);
          end else if (menu_open) begin
            menu_open = 1'b0;
            // lock time entry closes silently and keeps any tag beep
            case (menu_entry)
              MENU_EXIT, MENU_SIX, MENU_TIMER: o.beep = BEEP_SHORT;
              MENU_OPEN: begin
                set_mode(FLAP_OPEN);
                o.beep = BEEP_SHORT;
              end
              MENU_SILENT: begin
                silent_on = !silent_on;
                o.beep = BEEP_SHORT;
              end
              MENU_THRESHOLD: begin
                light_thr = light_now;
                o.beep = BEEP_SHORT;
              end
              default: ;
            endcase
          end else if (t > short_ms) begin
            menu_open = 1'b1;
            menu_entry = MENU_FIRST;
            o.beep = BEEP_LONG;
          end
        end
        default: ;
      endcase

      if (menu_open) o.green_ind = 1'b1;
      o.mode        = flap_mode;
      o.out_lock    = out_locked;
      o.in_lock     = in_locked;
      o.menu_active = menu_open;
      o.menu_item   = menu_entry;
      expected_outcomes.push_back(o);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [23:0] d);
      flap_outcome_t e;
      if (expected_outcomes.size() == 0) begin
        $error("result 0x%06h with no outcome expected", d);
        failures++;
        return;
      end
      e = expected_outcomes.pop_front();
      compare("mode_now", 8'(e.mode), 8'(d[2:0]));
      compare("out_lock", 8'(e.out_lock), 8'(d[3]));
      compare("in_lock", 8'(e.in_lock), 8'(d[4]));
      compare("green_ind", 8'(e.green_ind), 8'(d[5]));
      compare("red_led", 8'(e.red_led), 8'(d[6]));
      compare("beep_kind", 8'(e.beep), 8'(d[9:7]));
      compare("beep_count", 8'(e.beep_count), 8'(d[12:10]));
      compare("learn_pulse", 8'(e.learn_pulse), 8'(d[13]));
      compare("clear_pulse", 8'(e.clear_pulse), 8'(d[14]));
      compare("menu_active", 8'(e.menu_active), 8'(d[15]));
      compare("menu_item", 8'(e.menu_item), 8'(d[18:16]));
      compare("admitted", 8'(e.admitted), 8'(d[19]));
      compare("padding", 8'd0, 8'(d[23:20]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_LOCK_RETURN;
  logic [15:0] cfg_data = '0;

  flap_checker sb = new();
  bit sender_gaps = 1'b1;
  int ticks_offered = 0;

  pet_flap_access_controller_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_tick(s_tdata, s_tuser[0]);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // result side: random stalls, one long hold-off and one stretch always ready
  initial begin
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 200 && cyc < 600) m_tready <= 1'b0;
      else if (cyc >= 1400 && cyc < 2000) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(99) >= 34);
    end
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

  task automatic offer_tick(input bit g, input bit r, input bit lv, input bit [9:0] level,
                            input bit tag);
    if (sender_gaps)
      while ($urandom_range(99) < 34) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, tag, level, r, g};
    s_tuser  <= lv;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ticks_offered++;
  endtask

  task automatic busy_tick(input bit g, input bit r);
    int level;
    bit lv;
    lv = ($urandom_range(3) == 0);
    case ($urandom_range(4))
      0, 1: level = $urandom_range(1023);
      2, 3: level = int'(sb.light_thr) + int'($urandom_range(140)) - 70;
      default: level = $urandom_range(7);
    endcase
    if (level < 0) level = 0;
    if (level > 1023) level = 1023;
    offer_tick(g, r, lv, level[9:0], $urandom_range(99) < 6);
  endtask

  task automatic hold_buttons(input bit g, input bit r, input int len);
    repeat (len) busy_tick(g, r);
  endtask

  // one button held for len ticks, then released
  task automatic press_one(input bit green, input int len);
    hold_buttons(green, !green, len);
    busy_tick(1'b0, 1'b0);
  endtask

  task automatic press_both(input int len);
    busy_tick(1'b1, 1'b0);
    hold_buttons(1'b1, 1'b1, len > 1 ? len - 1 : 1);
    busy_tick(1'b0, 1'b0);
  endtask

  function automatic int pick_len();
    int base;
    case ($urandom_range(5))
      0: base = int'(sb.short_ms);
      1: base = int'(sb.vet_ms);
      2: base = int'(sb.learn_ms);
      3: base = int'(sb.long_ms);
      default: return int'($urandom_range(1, 8));
    endcase
    base = base + int'($urandom_range(2)) - 1;
    if (base < 1) base = 1;
    if (base > 60) base = int'($urandom_range(40, 60));
    return base;
  endfunction

  task automatic menu_session();
    int steps;
    int len;
    len = int'(sb.short_ms) + int'($urandom_range(1, 3));
    if (len > 60) len = int'($urandom_range(40, 60));
    press_both(len);
    steps = $urandom_range(8);
    repeat (steps) press_one(1'($urandom_range(1)), $urandom_range(1, 3));
    press_both($urandom_range(2, 3));
  endtask

  task automatic random_gesture();
    int len;
    len = pick_len();
    case ($urandom_range(19))
      0, 1, 2, 3, 4: menu_session();
      5, 6, 7: press_one(1'b1, len);
      8, 9, 10, 11: press_one(1'b0, len);
      12, 13, 14: begin
        // both buttons, sometimes red first, sometimes red outlasting green
        if ($urandom_range(3) == 0) hold_buttons(1'b0, 1'b1, $urandom_range(1, 3));
        busy_tick(1'b1, 1'($urandom_range(1)));
        hold_buttons(1'b1, 1'b1, len > 1 ? len - 1 : 1);
        if ($urandom_range(1)) hold_buttons(1'b0, 1'b1, $urandom_range(1, 4));
        busy_tick(1'b0, 1'b0);
      end
      15, 16: repeat ($urandom_range(1, 6))
        busy_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      default: hold_buttons(1'b0, 1'b0, $urandom_range(1, 10));
    endcase
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] lock_ms, input logic [15:0] gap,
                               input logic [15:0] short_ms, input logic [15:0] vet_ms,
                               input logic [15:0] learn_ms, input logic [15:0] long_ms);
    logic [15:0] vals [6];
    logic [2:0]  regs [6];
    vals = '{lock_ms, gap, short_ms, vet_ms, learn_ms, long_ms};
    regs = '{REG_LOCK_RETURN, REG_NIGHT_GAP, REG_SHORT_PRESS,
             REG_VET_PRESS, REG_LEARN_PRESS, REG_LONG_HOLD};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase_start;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed ticks on the reset settings
    offer_tick(0, 0, 0, 10'd0, 0);
    offer_tick(0, 0, 0, 10'd0, 1);        // tag admitted in normal mode
    offer_tick(1, 1, 1, 10'd1023, 1);     // all inputs high, unlock already running
    offer_tick(1, 1, 0, 10'd0, 0);
    offer_tick(0, 0, 0, 10'd0, 0);        // short both press does nothing
    offer_tick(0, 1, 0, 10'd0, 0);
    offer_tick(0, 0, 0, 10'd0, 0);        // short red press enters night mode
    offer_tick(0, 0, 1, 10'd0, 0);        // level falls to zero, outer latch stays released
    offer_tick(0, 0, 1, 10'd512, 0);
    offer_tick(0, 0, 1, 10'd513, 0);      // just above threshold locks
    offer_tick(0, 0, 1, 10'd506, 0);      // gap below threshold releases
    offer_tick(0, 0, 1, 10'd507, 0);
    offer_tick(0, 0, 0, 10'd0, 1);        // tag in night mode
    offer_tick(0, 1, 0, 10'd0, 0);
    offer_tick(0, 0, 0, 10'd0, 0);        // night off relocks and cancels the timer
    offer_tick(0, 0, 0, 10'd0, 1);
    offer_tick(0, 1, 0, 10'd0, 0);        // red first, green joins and leaves early
    offer_tick(1, 1, 0, 10'd0, 0);
    offer_tick(0, 1, 0, 10'd0, 0);
    offer_tick(0, 0, 0, 10'd0, 0);        // red release still counts as a red press
    offer_tick(0, 0, 1, 10'd341, 0);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: load_settings(16'd1000, 16'd5, 16'd6, 16'd14, 16'd20, 16'd30);
        1: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
        2: load_settings(16'h7FFF, 16'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        3: load_settings(16'd25000, 16'd63, 16'd4, 16'd9, 16'd12, 16'd18);
        4: load_settings(16'($urandom_range(1000, 1200)), 16'($urandom_range(63)),
                         16'($urandom_range(10)), 16'($urandom_range(20)),
                         16'($urandom_range(30)), 16'($urandom_range(10, 45)));
        default: load_settings(16'd999, 16'd17, 16'd3, 16'd7, 16'd10, 16'd25);
      endcase
      sender_gaps = (phase != 3);
      phase_start = ticks_offered;
      while (ticks_offered - phase_start < 225) random_gesture();
    end

    drain();
    repeat (6) @(posedge clk);
    if (sb.failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
